>>> rtl/uhist_pkg.sv
// Shared constants, command/status structs and encodings for the uniform bin histogram.
package uhist_pkg;

   // Default number of counter entries.
   localparam int unsigned MAX_BINS_DEFAULT = 256;

   // Field widths.
   localparam int unsigned REQ_W     = 2;
   localparam int unsigned VAL_W     = 32;
   localparam int unsigned WIDTH_W   = 31;
   localparam int unsigned BINS_W    = 9;
   localparam int unsigned READ_W    = 8;
   localparam int unsigned NUM_W     = 8;
   localparam int unsigned CNT_W     = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // Serial divider length: one quotient bit per cycle.
   localparam int unsigned DIV_STEPS = VAL_W;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_EDGE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_IN_USE = 2'd2;

   // Configuration reset values.
   localparam logic [VAL_W-1:0]   LOW_EDGE_RESET    = 32'd0;
   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET   = 31'd65536;
   localparam logic [BINS_W-1:0]  BINS_IN_USE_RESET = 9'd256;

   // What the datapath loads into the result register.
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ZERO,
      EMIT_ECHO,
      EMIT_BIN
   } emit_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          capture;
      logic          div_start;
      logic          idx_quot;
      logic          idx_read;
      logic          idx_zero;
      logic          clr_step;
      logic          mem_rd;
      logic          bump;
      emit_kind_type emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic below;
      logic read_ok;
      logic div_done;
      logic clr_last;
   } stat_type;

endpackage

>>> rtl/uhist_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module uhist_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [uhist_pkg::VAL_W-1:0]     dividend,
   input  logic [uhist_pkg::WIDTH_W-1:0]   divisor,
   output logic                            done,
   output logic [uhist_pkg::VAL_W-1:0]     quotient
);
   import uhist_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_in;
   logic [VAL_W-1:0]     quo_ff;
   logic [VAL_W-1:0]     quo_in;
   logic [WIDTH_W-1:0]   rem_ff;
   logic [WIDTH_W-1:0]   rem_in;
   logic [WIDTH_W-1:0]   dvs_ff;
   logic [WIDTH_W-1:0]   dvs_in;
   logic [VAL_W-1:0]     trial;
   logic [VAL_W-1:0]     trial_diff;
   logic                 fits;
   logic                 last_step;

   // Shift the next dividend bit into the remainder and try a subtraction.
   assign trial      = {rem_ff, quo_ff[VAL_W-1]};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign fits       = (trial >= {1'b0, dvs_ff});
   assign last_step  = (step_ff == STEP_W'(DIV_STEPS - 1));

   // Next-state logic for the iteration.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VAL_W-2:0], fits};
         rem_in  = fits ? trial_diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/uhist_dpath.sv
// Datapath: configuration registers, bin index divider, counter memory and result register.
module uhist_dpath #(
   parameter int unsigned MAX_BINS = uhist_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  uhist_pkg::cmd_type                  cmd,
   output uhist_pkg::stat_type                 stat,
   input  logic signed [uhist_pkg::VAL_W-1:0]  req_sample_value,
   input  logic [uhist_pkg::READ_W-1:0]        req_read_index,
   input  logic                                csr_we,
   input  logic [uhist_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uhist_pkg::VAL_W-1:0]         csr_wdata,
   output logic                                rsp_strobe,
   output logic [uhist_pkg::NUM_W-1:0]         rsp_bin_number,
   output logic [uhist_pkg::CNT_W-1:0]         rsp_bin_total,
   output logic signed [uhist_pkg::VAL_W-1:0]  rsp_bin_lower_edge,
   output logic                                rsp_hit_valid,
   output logic                                rsp_total_saturated
);
   import uhist_pkg::*;

   localparam int unsigned IW = $clog2(MAX_BINS);
   localparam int unsigned NW = (IW + 1 > BINS_W) ? IW + 1 : BINS_W;
   localparam int unsigned CW = (IW > NUM_W) ? IW : NUM_W;
   localparam int unsigned PW = WIDTH_W + IW;
   localparam int unsigned SW = PW + 2;

   logic [VAL_W-1:0]   low_edge_ff;
   logic [WIDTH_W-1:0] bin_width_ff;
   logic [BINS_W-1:0]  bins_in_use_ff;
   logic [VAL_W-1:0]   sample_ff;
   logic [READ_W-1:0]  read_ff;
   logic [IW-1:0]      work_index_ff;
   logic [IW-1:0]      work_index_in;
   logic [CNT_W-1:0]   cnt_mem [MAX_BINS];
   logic [CNT_W-1:0]   rd_data_ff;
   logic [PW-1:0]      prod_ff;

   logic [VAL_W:0]     diff;
   logic [WIDTH_W-1:0] width_used;
   logic [NW-1:0]      bins_ext;
   logic [IW-1:0]      last_idx;
   logic [VAL_W-1:0]   quotient;
   logic [IW-1:0]      quot_idx;
   logic               div_done;
   logic               clr_last;
   logic               mem_we;
   logic [CNT_W-1:0]   mem_wdata;
   logic [CNT_W-1:0]   cnt_inc;
   logic [CNT_W-1:0]   total_sel;
   logic [SW-1:0]      edge_sum;
   logic               edge_sat;
   logic [VAL_W-1:0]   edge_val;
   logic [CW-1:0]      idx_ext;

   logic               strobe_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   num_in;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   total_in;
   logic [VAL_W-1:0]   edge_ff;
   logic [VAL_W-1:0]   edge_in;
   logic               hit_ff;
   logic               hit_in;
   logic               sat_ff;
   logic               sat_in;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_edge_ff    <= LOW_EDGE_RESET;
         bin_width_ff   <= BIN_WIDTH_RESET;
         bins_in_use_ff <= BINS_IN_USE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_EDGE:    low_edge_ff    <= csr_wdata;
            CSR_BIN_WIDTH:   bin_width_ff   <= csr_wdata[WIDTH_W-1:0];
            CSR_BINS_IN_USE: bins_in_use_ff <= csr_wdata[BINS_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture on an accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample_value;
         read_ff   <= req_read_index;
      end
   end

   // Effective width and last bin index after range limiting.
   assign width_used = (bin_width_ff == '0) ? WIDTH_W'(1) : bin_width_ff;
   assign bins_ext   = NW'(bins_in_use_ff);

   always_comb begin
      priority if (bins_in_use_ff == '0) begin
         last_idx = '0;
      end else if (bins_ext > NW'(MAX_BINS)) begin
         last_idx = IW'(MAX_BINS - 1);
      end else begin
         last_idx = IW'(bins_ext - NW'(1));
      end
   end

   // Distance of the sample from the lower edge; the sign bit flags a drop.
   assign diff = {sample_ff[VAL_W-1], sample_ff} - {low_edge_ff[VAL_W-1], low_edge_ff};

   uhist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff[VAL_W-1:0]),
      .divisor  (width_used),
      .done     (div_done),
      .quotient (quotient)
   );

   // The top bin is open upward.
   assign quot_idx = (quotient > VAL_W'(last_idx)) ? last_idx : quotient[IW-1:0];
   assign clr_last = (work_index_ff == IW'(MAX_BINS - 1));

   // Work index: bin under update, or the sweep position while clearing.
   always_comb begin
      priority if (cmd.idx_zero) begin
         work_index_in = '0;
      end else if (cmd.clr_step) begin
         work_index_in = clr_last ? '0 : work_index_ff + IW'(1);
      end else if (cmd.idx_quot) begin
         work_index_in = quot_idx;
      end else if (cmd.idx_read) begin
         work_index_in = IW'(read_ff);
      end else begin
         work_index_in = work_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_index_ff <= '0;
      end else begin
         work_index_ff <= work_index_in;
      end
   end

   // Counter memory: one port addressed by the work index, registered read.
   assign cnt_inc   = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + CNT_W'(1);
   assign mem_we    = cmd.clr_step | cmd.bump;
   assign mem_wdata = cmd.clr_step ? '0 : cnt_inc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[work_index_ff] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= cnt_mem[work_index_ff];
      end
   end

   // Bin offset product, registered beside the memory read.
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         prod_ff <= PW'(work_index_ff) * PW'(width_used);
      end
   end

   // Lower edge; the sum never falls below the Q16.16 range, so only the top saturates.
   assign edge_sum = {{(SW - VAL_W){low_edge_ff[VAL_W-1]}}, low_edge_ff}
                   + {{(SW - PW){1'b0}}, prod_ff};
   assign edge_sat = !edge_sum[SW-1] && (|edge_sum[SW-2:VAL_W-1]);
   assign edge_val = edge_sat ? {1'b0, {(VAL_W - 1){1'b1}}} : edge_sum[VAL_W-1:0];

   assign total_sel = cmd.bump ? cnt_inc : rd_data_ff;
   assign idx_ext   = CW'(work_index_ff);

   // Result register contents.
   always_comb begin
      num_in   = '0;
      total_in = '0;
      edge_in  = '0;
      hit_in   = 1'b0;
      sat_in   = 1'b0;
      unique case (cmd.emit)
         EMIT_BIN: begin
            num_in   = idx_ext[NUM_W-1:0];
            total_in = total_sel;
            edge_in  = edge_val;
            hit_in   = 1'b1;
            sat_in   = (total_sel == '1);
         end
         EMIT_ECHO: begin
            num_in = NUM_W'(read_ff);
         end
         EMIT_ZERO, EMIT_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.emit != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         num_ff   <= num_in;
         total_ff <= total_in;
         edge_ff  <= edge_in;
         hit_ff   <= hit_in;
         sat_ff   <= sat_in;
      end
   end

   // Status back to the controller.
   assign stat.below    = diff[VAL_W];
   assign stat.read_ok  = (CW'(read_ff) <= CW'(last_idx));
   assign stat.div_done = div_done;
   assign stat.clr_last = clr_last;

   assign rsp_strobe          = strobe_ff;
   assign rsp_bin_number      = num_ff;
   assign rsp_bin_total       = total_ff;
   assign rsp_bin_lower_edge  = edge_ff;
   assign rsp_hit_valid       = hit_ff;
   assign rsp_total_saturated = sat_ff;

endmodule

>>> rtl/uhist_ctrl.sv
// Controller: sequences request handling, the divider wait and the counter clearing sweep.
module uhist_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [uhist_pkg::REQ_W-1:0]   req_type,
   output logic                          busy,
   output uhist_pkg::cmd_type            cmd,
   input  uhist_pkg::stat_type           stat
);
   import uhist_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_ADD_RD,
      ST_ADD_UPD,
      ST_RD_CHK,
      ST_RD_RD,
      ST_RD_OUT,
      ST_CLEAR,
      ST_EMPTY
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Commands and next state for each phase.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = EMIT_NONE;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_type)
                  REQ_ADD:   state_in = ST_CHECK;
                  REQ_READ:  state_in = ST_RD_CHK;
                  REQ_CLEAR: begin
                     cmd.idx_zero = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default:   state_in = ST_EMPTY;
               endcase
            end
         end
         ST_CHECK: begin
            if (stat.below) begin
               cmd.emit = EMIT_ZERO;
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.idx_quot = 1'b1;
               state_in     = ST_ADD_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_ADD_UPD;
         end
         ST_ADD_UPD: begin
            cmd.bump = 1'b1;
            cmd.emit = EMIT_BIN;
            state_in = ST_IDLE;
         end
         ST_RD_CHK: begin
            if (stat.read_ok) begin
               cmd.idx_read = 1'b1;
               state_in     = ST_RD_RD;
            end else begin
               cmd.emit = EMIT_ECHO;
               state_in = ST_IDLE;
            end
         end
         ST_RD_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            cmd.emit = EMIT_BIN;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.emit = EMIT_ZERO;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            cmd.emit = EMIT_ZERO;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/uniform_bin_histogram_unit.sv
// Top level of the uniform bin histogram: controller plus datapath.
//
// Usage: a request beat is taken at a rising edge where start is high and busy
// is low; req_type selects add sample (0), read bin (1) or clear all (2).
// Each request yields exactly one result beat: rsp_strobe is high for one
// cycle with the rsp_ fields. The receiver cannot stall, so results are never
// held back; busy falls in the cycle that carries the strobe, and a new
// request may be taken in that same cycle.
// Path from the accepting edge to the strobe cycle:
//   add in range  - check state, the one bit per cycle divider, its
//                   registered done, memory read, update.
//   add below low_edge - check state.   type 3 - one state emitting zeros.
//   read - check, memory read, output (check state alone when out of range).
//   clear - sweep of all MAX_BINS entries, one counter entry per cycle.
// Reset: the counter memory is swept to zero, one entry per cycle, and busy
// stays high until the sweep ends. Configuration writes on the csr_ port
// are taken at any edge with csr_we high, including the sweep.
module uniform_bin_histogram_unit #(
   parameter int unsigned MAX_BINS = uhist_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [uhist_pkg::REQ_W-1:0]         req_type,
   input  logic signed [uhist_pkg::VAL_W-1:0]  req_sample_value,
   input  logic [uhist_pkg::READ_W-1:0]        req_read_index,
   output logic                                rsp_strobe,
   output logic [uhist_pkg::NUM_W-1:0]         rsp_bin_number,
   output logic [uhist_pkg::CNT_W-1:0]         rsp_bin_total,
   output logic signed [uhist_pkg::VAL_W-1:0]  rsp_bin_lower_edge,
   output logic                                rsp_hit_valid,
   output logic                                rsp_total_saturated,
   input  logic                                csr_we,
   input  logic [uhist_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uhist_pkg::VAL_W-1:0]         csr_wdata
);
   import uhist_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   uhist_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .stat     (stat)
   );

   uhist_dpath #(
      .MAX_BINS (MAX_BINS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_sample_value    (req_sample_value),
      .req_read_index      (req_read_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_bin_number      (rsp_bin_number),
      .rsp_bin_total       (rsp_bin_total),
      .rsp_bin_lower_edge  (rsp_bin_lower_edge),
      .rsp_hit_valid       (rsp_hit_valid),
      .rsp_total_saturated (rsp_total_saturated)
   );

   // A result beat always arrives with the controller back in idle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result beat while controller busy");

   // An accepted request keeps the block busy until its result is produced.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not occupy the controller");

   // A miss carries no count and no edge.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit_valid) |->
         (rsp_bin_total == '0 && rsp_bin_lower_edge == '0 && !rsp_total_saturated))
      else $error("miss result carries nonzero payload");

   // The saturation flag matches an all-ones count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit_valid) |-> (rsp_total_saturated == (rsp_bin_total == '1)))
      else $error("saturation flag disagrees with count");

endmodule
